[sv/spiral_order_index_mapper_core_macros.svh]
// ---------------------------------------------------------------------------
// Spiral order index mapper assertion macros
// Shared concurrent assertion forms for the controller and the datapath.
// ---------------------------------------------------------------------------
`ifndef SPIRAL_ORDER_INDEX_MAPPER_CORE_MACROS_SVH
`define SPIRAL_ORDER_INDEX_MAPPER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOM_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spiral mapper assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SOM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spiral mapper assertion failed");

`endif

[sv/som_pkg.sv]
// ---------------------------------------------------------------------------
// Spiral order index mapper package
// Field widths, transaction payloads and controller/datapath handshake types.
// ---------------------------------------------------------------------------
package som_pkg;

	localparam int DIM_W  = 11;          // row/column count width
	localparam int POS_W  = 10;          // row/column position width
	localparam int IDX_W  = 20;          // spiral index width
	localparam int PROD_W = 2 * DIM_W;   // grid size and ring start width
	localparam int OFF_W  = DIM_W + 2;   // offset inside one ring
	localparam int CFG_IDX_W = 1;

	localparam int PERIM_ADJ = 4;        // corners counted twice in 2*(h+w)

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

	localparam logic CMD_POS_TO_IDX = 1'b0;
	localparam logic CMD_IDX_TO_POS = 1'b1;

	typedef struct packed {
		logic             command;
		logic [POS_W-1:0] row_in;
		logic [POS_W-1:0] col_in;
		logic [IDX_W-1:0] index_in;
	} som_in_t;

	typedef struct packed {
		logic [POS_W-1:0] row_out;
		logic [POS_W-1:0] col_out;
		logic [IDX_W-1:0] index_out;
		logic             out_of_range;
	} som_out_t;

	typedef struct packed {
		logic load;   // capture the request operands
		logic prep;   // range check, ring target, walk init
		logic step;   // advance one ring when allowed
		logic offs;   // compute the offset inside the ring
		logic emit;   // load the result register
	} som_cmd_t;

	typedef struct packed {
		logic walk_more;
	} som_status_t;

endpackage

[sv/som_stream_if.sv]
// ---------------------------------------------------------------------------
// Spiral order index mapper stream interface
// Valid/ready channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
interface som_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/spiral_order_index_mapper_core.sv]
// ---------------------------------------------------------------------------
// Spiral order index mapper core
// Maps grid positions to clockwise spiral indexes and back.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one transaction per request: command 0 turns (row_in, col_in)
//   into its spiral index, command 1 turns index_in into (row, col).
//   rsp returns one transaction per request, in order; out_of_range flags an
//   operand outside the configured grid, with all other fields zero.
//   cfg_wr_en/cfg_index/cfg_data write row_count (index 0) and col_count
//   (index 1); write them only while no request is in flight.
// Ring walk and request flow:
//   rsp.valid rises once the ring walk for the request is done; the walk stops
//   at the ring k that holds the cell (ring 0 for an out-of-range operand); the ring
//   walker advances one ring per cycle. The sequencer is idle again in the
//   same cycle that rsp.valid rises, so a new request can be accepted then.
//   With 1024-by-1024 grids k reaches 511.
//   One request is worked at a time; req.ready is high only when idle.
// Reset and stalls:
//   Reset clears the sequencer and sets both counts to 1. A result waiting
//   in the output register does not block the next request; the sequencer
//   holds its final step only if that register is still full and rsp.ready is low.
// ---------------------------------------------------------------------------
module spiral_order_index_mapper_core #(
	parameter int MAX_DIM = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	som_stream_if.sink                      req,
	som_stream_if.source                    rsp,
	input  logic                            cfg_wr_en,
	input  logic [som_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [som_pkg::DIM_W-1:0]       cfg_data
);
	import som_pkg::*;

	// largest effective count, bounded by what an 11-bit register can hold
	localparam int DIM_CAP = (MAX_DIM < 2047) ? MAX_DIM : 2047;
	// ring counter width: rings number at most half the shorter side
	localparam int K_W = $clog2(DIM_CAP / 2 + 1);

	som_cmd_t    cmd;
	som_status_t status;
	som_out_t    result;
	logic        rsp_valid;

	// sequencer: owns the request/response handshakes
	som_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// grid registers, ring walker and result register
	som_dpath #(
		.MAX_DIM (MAX_DIM),
		.K_W     (K_W)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.operand   (req.data),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

	// drive the response channel from the output register
	assign rsp.valid = rsp_valid;
	assign rsp.data  = result;

endmodule

[sv/som_ctrl.sv]
// ---------------------------------------------------------------------------
// Spiral order index mapper controller
// Sequences one transaction through prep, ring walk, offset and map steps.
// ---------------------------------------------------------------------------
`include "spiral_order_index_mapper_core_macros.svh"

module som_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  som_pkg::som_status_t status,
	output som_pkg::som_cmd_t    cmd
);
	import som_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PREP = 5'b00010,
		ST_WALK = 5'b00100,
		ST_OFFS = 5'b01000,
		ST_MAP  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_WALK;
			end
			ST_WALK: begin
				cmd.step = 1'b1;
				if (!status.walk_more) begin
					state_d = ST_OFFS;
				end
			end
			ST_OFFS: begin
				cmd.offs = 1'b1;
				state_d  = ST_MAP;
			end
			ST_MAP: begin
				// hold until the result register is free or draining
				if (!out_valid_q || rsp_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`SOM_ASSERT_NEXT(a_accept_to_prep, clk, arst_n, req_valid && req_ready, state_q == ST_PREP)
	`SOM_ASSERT_NEXT(a_emit_sets_valid, clk, arst_n, cmd.emit, out_valid_q)
	`SOM_ASSERT_NEXT(a_walk_exit, clk, arst_n, state_q == ST_WALK && !status.walk_more, state_q == ST_OFFS)

endmodule

[sv/som_dpath.sv]
// ---------------------------------------------------------------------------
// Spiral order index mapper datapath
// Grid registers, ring walker, ring offset logic and result register.
// ---------------------------------------------------------------------------
`include "spiral_order_index_mapper_core_macros.svh"

module som_dpath #(
	parameter int MAX_DIM = 1024,
	parameter int K_W     = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [som_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [som_pkg::DIM_W-1:0]           cfg_data,
	input  som_pkg::som_in_t                    operand,
	input  som_pkg::som_cmd_t                   cmd,
	output som_pkg::som_status_t                status,
	output som_pkg::som_out_t                   result
);
	import som_pkg::*;

	// grid size registers
	logic [DIM_W-1:0] row_count_q, col_count_q;
	logic [DIM_W-1:0] m, n;

	// operand registers
	logic             cmd_q;
	logic [POS_W-1:0] ri_q, ci_q;
	logic [IDX_W-1:0] xi_q;

	// walk state
	logic             oor_q;
	logic [K_W-1:0]   k_q, ktgt_q;
	logic [PROD_W-1:0] s_q;
	logic [DIM_W-1:0] h_q, w_q;
	logic [OFF_W-1:0] off_q;
	som_out_t         result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= DIM_W'(1);
			col_count_q <= DIM_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ROW_COUNT: row_count_q <= cfg_data;
				CFG_COL_COUNT: col_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// saturate counts to the largest supported dimension
	assign m = (32'(row_count_q) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : row_count_q;
	assign n = (32'(col_count_q) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : col_count_q;

	// ---- prep: range check and ring target
	logic [PROD_W-1:0] grid_cells;
	logic              oor_d;
	logic [DIM_W-1:0]  ri_w, ci_w, d_bot, d_rgt, kmin, mn_min, kmax;

	always_comb begin
		grid_cells = PROD_W'(m) * PROD_W'(n);
		ri_w       = DIM_W'(ri_q);
		ci_w       = DIM_W'(ci_q);
		d_bot      = m - DIM_W'(1) - ri_w;
		d_rgt      = n - DIM_W'(1) - ci_w;
		kmin       = ri_w;
		if (ci_w < kmin) kmin = ci_w;
		if (d_bot < kmin) kmin = d_bot;
		if (d_rgt < kmin) kmin = d_rgt;
		mn_min     = (m < n) ? m : n;
		kmax       = (mn_min - DIM_W'(1)) >> 1;
		if (cmd_q == CMD_POS_TO_IDX) begin
			oor_d = (ri_w >= m) || (ci_w >= n);
		end else begin
			oor_d = (PROD_W'(xi_q) >= grid_cells);
		end
	end

	// ---- walk: one ring per cycle, start advances by the ring perimeter
	logic [PROD_W-1:0] s_nxt;

	assign s_nxt = ((PROD_W'(h_q) + PROD_W'(w_q)) << 1) - PROD_W'(PERIM_ADJ);
	assign status.walk_more = !oor_q && (k_q < ktgt_q)
		&& ((cmd_q == CMD_POS_TO_IDX) || ((s_q + s_nxt) <= PROD_W'(xi_q)));

	// ---- offset inside the ring
	logic [OFF_W-1:0] k13, ri13, ci13, m13, n13, h13, w13, off_d;

	always_comb begin
		k13  = OFF_W'(k_q);
		ri13 = OFF_W'(ri_q);
		ci13 = OFF_W'(ci_q);
		m13  = OFF_W'(m);
		n13  = OFF_W'(n);
		h13  = OFF_W'(h_q);
		w13  = OFF_W'(w_q);
		if (cmd_q == CMD_IDX_TO_POS) begin
			off_d = OFF_W'(PROD_W'(xi_q) - s_q);
		end else if (ri13 == k13) begin
			off_d = ci13 - k13;
		end else if (ci13 == n13 - OFF_W'(1) - k13) begin
			off_d = (w13 - OFF_W'(1)) + (ri13 - k13);
		end else if (ri13 == m13 - OFF_W'(1) - k13) begin
			off_d = (w13 - OFF_W'(1)) + (h13 - OFF_W'(1)) + (n13 - OFF_W'(1) - k13 - ci13);
		end else begin
			off_d = ((w13 - OFF_W'(1)) << 1) + (h13 - OFF_W'(1))
				+ (m13 - OFF_W'(1) - k13 - ri13);
		end
	end

	// ---- map: position from offset, or index from ring start
	logic [OFF_W-1:0]  r_d, c_d;
	logic [PROD_W-1:0] x_sum;
	som_out_t          result_d;

	always_comb begin
		x_sum = s_q + PROD_W'(off_q);
		if (off_q < w13) begin
			r_d = k13;
			c_d = k13 + off_q;
		end else if (off_q < w13 + h13 - OFF_W'(1)) begin
			r_d = k13 + (off_q - (w13 - OFF_W'(1)));
			c_d = n13 - OFF_W'(1) - k13;
		end else if (off_q < (w13 << 1) + h13 - OFF_W'(2)) begin
			r_d = m13 - OFF_W'(1) - k13;
			c_d = n13 - OFF_W'(1) - k13 - (off_q - (w13 - OFF_W'(1)) - (h13 - OFF_W'(1)));
		end else begin
			r_d = m13 - OFF_W'(1) - k13
				- (off_q - ((w13 - OFF_W'(1)) << 1) - (h13 - OFF_W'(1)));
			c_d = k13;
		end
		if (oor_q) begin
			result_d = '0;
			result_d.out_of_range = 1'b1;
		end else if (cmd_q == CMD_POS_TO_IDX) begin
			result_d.row_out      = ri_q;
			result_d.col_out      = ci_q;
			result_d.index_out    = IDX_W'(x_sum);
			result_d.out_of_range = 1'b0;
		end else begin
			result_d.row_out      = POS_W'(r_d);
			result_d.col_out      = POS_W'(c_d);
			result_d.index_out    = xi_q;
			result_d.out_of_range = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= operand.command;
			ri_q  <= operand.row_in;
			ci_q  <= operand.col_in;
			xi_q  <= operand.index_in;
		end
		if (cmd.prep) begin
			oor_q  <= oor_d;
			ktgt_q <= (cmd_q == CMD_POS_TO_IDX) ? K_W'(kmin) : K_W'(kmax);
			k_q    <= '0;
			s_q    <= '0;
			h_q    <= m;
			w_q    <= n;
		end
		if (cmd.step && status.walk_more) begin
			k_q <= k_q + K_W'(1);
			s_q <= s_q + s_nxt;
			h_q <= h_q - DIM_W'(2);
			w_q <= w_q - DIM_W'(2);
		end
		if (cmd.offs) begin
			off_q <= off_d;
		end
		if (cmd.emit) begin
			result_q <= result_d;
		end
	end

	assign result = result_q;

	`SOM_ASSERT_NEXT(a_walk_increments, clk, arst_n, cmd.step && status.walk_more, k_q == K_W'($past(k_q) + K_W'(1)))
	`SOM_ASSERT_IMPL(a_start_below_index, clk, arst_n, $past(cmd.step) && !oor_q && cmd_q == CMD_IDX_TO_POS, s_q <= PROD_W'(xi_q))
	`SOM_ASSERT_NEXT(a_oor_zero, clk, arst_n, cmd.emit && oor_q, result_q.out_of_range && result_q.index_out == '0 && result_q.row_out == '0 && result_q.col_out == '0)

endmodule
